FILE: sv/dmc_pkg.sv
package dmc_pkg;

    // Fixed word width of the cache and the backing memory.
    localparam int DATA_BITS = 32;

    // Default geometry: 64K words of backing memory, 256 lines of four words.
    localparam int ADDR_BITS_DEF      = 16;
    localparam int INDEX_BITS_DEF     = 8;
    localparam int WORDS_PER_LINE_DEF = 4;
    localparam int OFFSET_BITS_DEF    = 2;
    localparam int TAG_BITS_DEF       = 6;

    // Function code of a request transaction.
    localparam logic FUNC_WRITE = 1'b1;

    // Commands from the controller to the tag, data and flag stores.
    typedef struct packed {
        logic lookup;      // read tag, flags and the addressed word
        logic data_rd;     // read one word of the line
        logic data_wr;     // write one word of the line
        logic fill_done;   // write the tag and set the line valid
        logic fill_dirty;  // dirty value given with fill_done
        logic mark_dirty;  // set the dirty flag of a hit line
    } line_ctrl_t;

    // Commands from the controller to the backing memory.
    typedef struct packed {
        logic rd;
        logic wr;
    } back_ctrl_t;

endpackage

FILE: sv/dmc_if.sv
// Request channel: one word access per transaction.
interface dmc_req_if import dmc_pkg::*; #(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [ADDR_BITS-1:0] address;
    logic [DATA_BITS-1:0] write_data;

    modport source (output valid, output func, output address, output write_data,
                    input ready);
    modport sink   (input valid, input func, input address, input write_data,
                    output ready);
endinterface

// Response channel: one result per request transaction.
interface dmc_rsp_if import dmc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [DATA_BITS-1:0] read_data;
    logic                 wrote_back;

    modport source (output valid, output hit, output read_data, output wrote_back,
                    input ready);
    modport sink   (input valid, input hit, input read_data, input wrote_back,
                    output ready);
endinterface

FILE: sv/direct_mapped_write_back_cache_unit.sv
// A hit is looked up in the line store and its result registered into the output slot; a
// miss on a clean or invalid line first fills the line from the backing memory, and a dirty
// miss writes the victim back before the fill. One request is in flight at a time.
// Throughput is set by the single-port line data and backing memories, one word a cycle.
// Reset clears the line flags at once, then sweeps all 2**ADDR_BITS words (65536 by
// default) of the backing memory to zero before the first request is taken.
module direct_mapped_write_back_cache_unit import dmc_pkg::*; #(
    parameter int ADDR_BITS      = ADDR_BITS_DEF,
    parameter int INDEX_BITS     = INDEX_BITS_DEF,
    parameter int WORDS_PER_LINE = WORDS_PER_LINE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dmc_req_if.sink    req,
    dmc_rsp_if.source  rsp
);

    localparam int OFFSET_BITS = $clog2(WORDS_PER_LINE);
    localparam int LINE_WORDS  = 1 << OFFSET_BITS;
    localparam int LINE_BITS   = INDEX_BITS + OFFSET_BITS;
    localparam int TAG_RAW     = ADDR_BITS - LINE_BITS;
    localparam int TAG_BITS    = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int EXT_BITS    = LINE_BITS + TAG_BITS;
    localparam int CNT_BITS    = OFFSET_BITS + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_WBACK,
        ST_FILL,
        ST_RESPOND
    } state_t;

    state_t                 state_reg, state_next;
    logic                   func_reg, func_next;
    logic [ADDR_BITS-1:0]   addr_reg, addr_next;
    logic [DATA_BITS-1:0]   wdata_reg, wdata_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                   pend_reg, pend_next;
    logic [OFFSET_BITS-1:0] pend_off_reg, pend_off_next;
    logic                   res_hit_reg, res_hit_next;
    logic [DATA_BITS-1:0]   res_data_reg, res_data_next;
    logic                   res_wb_reg, res_wb_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_hit_reg, out_hit_next;
    logic [DATA_BITS-1:0]   out_data_reg, out_data_next;
    logic                   out_wb_reg, out_wb_next;

    logic [EXT_BITS-1:0]    in_ext;
    logic [EXT_BITS-1:0]    cur_ext;
    logic [INDEX_BITS-1:0]  cur_idx;
    logic [OFFSET_BITS-1:0] cur_off;
    logic [TAG_BITS-1:0]    cur_tag;
    logic [OFFSET_BITS-1:0] cnt_off;
    logic                   cnt_done;
    logic                   accept;
    logic                   slot_free;
    logic                   clr_busy;

    logic                   fin_valid;
    logic                   fin_hit;
    logic [DATA_BITS-1:0]   fin_data;
    logic                   fin_wb;
    logic [DATA_BITS-1:0]   fill_word;

    line_ctrl_t             line_ctrl;
    logic [INDEX_BITS-1:0]  line_idx;
    logic [LINE_BITS-1:0]   line_addr;
    logic [DATA_BITS-1:0]   line_wdata;
    logic [TAG_BITS-1:0]    tag_rd;
    logic [DATA_BITS-1:0]   data_rd;
    logic                   valid_rd;
    logic                   dirty_rd;

    back_ctrl_t             back_ctrl;
    logic [ADDR_BITS-1:0]   back_addr;
    logic [DATA_BITS-1:0]   back_rd;

    // Address split: offset, index, and every bit above the index as tag.
    assign in_ext   = EXT_BITS'(req.address);
    assign cur_ext  = EXT_BITS'(addr_reg);
    assign cur_off  = cur_ext[OFFSET_BITS-1:0];
    assign cur_idx  = cur_ext[LINE_BITS-1:OFFSET_BITS];
    assign cur_tag  = cur_ext[EXT_BITS-1:LINE_BITS];
    assign cnt_off  = cnt_reg[OFFSET_BITS-1:0];
    assign cnt_done = (cnt_reg == CNT_BITS'(LINE_WORDS));

    // Handshakes: a new request only when idle and the clearing sweep is done; the output slot frees as it drains.
    assign req.ready = (state_reg == ST_IDLE) && !clr_busy;
    assign accept    = req.valid && req.ready;
    assign slot_free = !out_valid_reg || rsp.ready;

    // Word arriving from the backing memory during a fill, merged with a write.
    assign fill_word = (func_reg == FUNC_WRITE && pend_off_reg == cur_off) ? wdata_reg
                                                                          : back_rd;

    // Controller: next state and memory commands.
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        addr_next      = addr_reg;
        wdata_next     = wdata_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        pend_off_next  = pend_off_reg;
        res_hit_next   = res_hit_reg;
        res_data_next  = res_data_reg;
        res_wb_next    = res_wb_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_hit_next   = out_hit_reg;
        out_data_next  = out_data_reg;
        out_wb_next    = out_wb_reg;

        fin_valid  = 1'b0;
        fin_hit    = res_hit_reg;
        fin_data   = res_data_reg;
        fin_wb     = res_wb_reg;

        line_ctrl  = '0;
        line_idx   = cur_idx;
        line_addr  = {cur_idx, cur_off};
        line_wdata = wdata_reg;
        back_ctrl  = '0;
        back_addr  = ADDR_BITS'({tag_rd, cur_idx, pend_off_reg});

        unique case (state_reg)
            ST_IDLE:
            begin
                line_idx  = in_ext[LINE_BITS-1:OFFSET_BITS];
                line_addr = in_ext[LINE_BITS-1:0];
                if (accept)
                begin
                    line_ctrl.lookup = 1'b1;
                    func_next        = req.func;
                    addr_next        = req.address;
                    wdata_next       = req.write_data;
                    state_next       = ST_LOOKUP;
                end
            end

            ST_LOOKUP:
            begin
                cnt_next  = '0;
                pend_next = 1'b0;
                if (valid_rd && tag_rd == cur_tag)
                begin
                    // Hit: read the word or write it and mark the line dirty.
                    fin_valid = 1'b1;
                    fin_hit   = 1'b1;
                    fin_wb    = 1'b0;
                    fin_data  = data_rd;
                    if (func_reg == FUNC_WRITE)
                    begin
                        line_ctrl.data_wr    = 1'b1;
                        line_ctrl.mark_dirty = 1'b1;
                        fin_data             = wdata_reg;
                    end
                end
                else
                begin
                    res_hit_next = 1'b0;
                    if (valid_rd && dirty_rd)
                    begin
                        res_wb_next = 1'b1;
                        state_next  = ST_WBACK;
                    end
                    else
                    begin
                        res_wb_next = 1'b0;
                        state_next  = ST_FILL;
                    end
                end
            end

            ST_WBACK:
            begin
                // Victim words go back to the victim's own address, one per cycle.
                if (pend_reg)
                begin
                    back_ctrl.wr = 1'b1;
                end
                line_addr = {cur_idx, cnt_off};
                if (!cnt_done)
                begin
                    line_ctrl.data_rd = 1'b1;
                    pend_next         = 1'b1;
                    pend_off_next     = cnt_off;
                    cnt_next          = cnt_reg + CNT_BITS'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_FILL;
                end
            end

            ST_FILL:
            begin
                // Fill the line from memory, merging the new word on a write.
                back_addr  = ADDR_BITS'({cur_tag, cur_idx, cnt_off});
                line_addr  = {cur_idx, pend_off_reg};
                line_wdata = fill_word;
                if (pend_reg)
                begin
                    line_ctrl.data_wr = 1'b1;
                    if (pend_off_reg == cur_off)
                    begin
                        res_data_next = fill_word;
                    end
                end
                if (!cnt_done)
                begin
                    back_ctrl.rd  = 1'b1;
                    pend_next     = 1'b1;
                    pend_off_next = cnt_off;
                    cnt_next      = cnt_reg + CNT_BITS'(1);
                end
                else
                begin
                    line_ctrl.fill_done  = 1'b1;
                    line_ctrl.fill_dirty = (func_reg == FUNC_WRITE);
                    pend_next            = 1'b0;
                    fin_valid            = 1'b1;
                    fin_hit              = 1'b0;
                    fin_wb               = res_wb_reg;
                    fin_data             = (pend_reg && pend_off_reg == cur_off) ? fill_word
                                                                              : res_data_reg;
                end
            end

            ST_RESPOND:
            begin
                fin_valid = 1'b1;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Hand a finished result to the output register, or hold it until free.
        if (fin_valid)
        begin
            res_hit_next  = fin_hit;
            res_data_next = fin_data;
            res_wb_next   = fin_wb;
            if (slot_free)
            begin
                out_valid_next = 1'b1;
                out_hit_next   = fin_hit;
                out_data_next  = fin_data;
                out_wb_next    = fin_wb;
                state_next     = ST_IDLE;
            end
            else
            begin
                state_next = ST_RESPOND;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            func_reg      <= 1'b0;
            addr_reg      <= '0;
            wdata_reg     <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_off_reg  <= '0;
            res_hit_reg   <= 1'b0;
            res_data_reg  <= '0;
            res_wb_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
            out_data_reg  <= '0;
            out_wb_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            addr_reg      <= addr_next;
            wdata_reg     <= wdata_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            pend_off_reg  <= pend_off_next;
            res_hit_reg   <= res_hit_next;
            res_data_reg  <= res_data_next;
            res_wb_reg    <= res_wb_next;
            out_valid_reg <= out_valid_next;
            out_hit_reg   <= out_hit_next;
            out_data_reg  <= out_data_next;
            out_wb_reg    <= out_wb_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.read_data  = out_data_reg;
    assign rsp.wrote_back = out_wb_reg;

    // Tags, line words and line flags.
    dmc_line_store #(
        .INDEX_BITS  (INDEX_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .TAG_BITS    (TAG_BITS)
    ) u_line_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (line_ctrl),
        .idx        (line_idx),
        .data_addr  (line_addr),
        .data_wdata (line_wdata),
        .tag_wdata  (cur_tag),
        .tag_rd     (tag_rd),
        .data_rd    (data_rd),
        .valid_rd   (valid_rd),
        .dirty_rd   (dirty_rd)
    );

    // Backing word memory with its clearing sweep.
    dmc_backing_mem #(
        .ADDR_BITS (ADDR_BITS)
    ) u_backing_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (back_ctrl),
        .addr    (back_addr),
        .wdata   (data_rd),
        .rd_data (back_rd),
        .busy    (clr_busy)
    );

endmodule

FILE: sv/dmc_line_store.sv
module dmc_line_store import dmc_pkg::*; #(
    parameter int INDEX_BITS  = INDEX_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  line_ctrl_t                        ctrl,
    input  logic [INDEX_BITS-1:0]             idx,
    input  logic [INDEX_BITS+OFFSET_BITS-1:0] data_addr,
    input  logic [DATA_BITS-1:0]              data_wdata,
    input  logic [TAG_BITS-1:0]               tag_wdata,
    output logic [TAG_BITS-1:0]               tag_rd,
    output logic [DATA_BITS-1:0]              data_rd,
    output logic                              valid_rd,
    output logic                              dirty_rd
);

    localparam int NUM_LINES = 1 << INDEX_BITS;
    localparam int NUM_WORDS = 1 << (INDEX_BITS + OFFSET_BITS);

    logic [TAG_BITS-1:0]  tag_mem  [NUM_LINES];
    logic [DATA_BITS-1:0] data_mem [NUM_WORDS];

    logic [TAG_BITS-1:0]  tag_rd_reg;
    logic [DATA_BITS-1:0] data_rd_reg;
    logic [NUM_LINES-1:0] valid_reg;
    logic [NUM_LINES-1:0] dirty_reg;
    logic                 valid_rd_reg;
    logic                 dirty_rd_reg;

    // Tag memory: read on lookup, written when a fill completes.
    always_ff @(posedge clk)
    begin
        if (ctrl.lookup)
        begin
            tag_rd_reg <= tag_mem[idx];
        end
        if (ctrl.fill_done)
        begin
            tag_mem[idx] <= tag_wdata;
        end
    end

    // Line data memory: one access per cycle, read data registered.
    always_ff @(posedge clk)
    begin
        if (ctrl.data_wr)
        begin
            data_mem[data_addr] <= data_wdata;
        end
        if (ctrl.lookup || ctrl.data_rd)
        begin
            data_rd_reg <= data_mem[data_addr];
        end
    end

    // Valid and dirty flags live in flip-flops so that reset clears them at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            dirty_reg    <= '0;
            valid_rd_reg <= 1'b0;
            dirty_rd_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.lookup)
            begin
                valid_rd_reg <= valid_reg[idx];
                dirty_rd_reg <= dirty_reg[idx];
            end
            if (ctrl.fill_done)
            begin
                valid_reg[idx] <= 1'b1;
                dirty_reg[idx] <= ctrl.fill_dirty;
            end
            else if (ctrl.mark_dirty)
            begin
                dirty_reg[idx] <= 1'b1;
            end
        end
    end

    assign tag_rd   = tag_rd_reg;
    assign data_rd  = data_rd_reg;
    assign valid_rd = valid_rd_reg;
    assign dirty_rd = dirty_rd_reg;

endmodule

FILE: sv/dmc_backing_mem.sv
module dmc_backing_mem import dmc_pkg::*; #(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  back_ctrl_t           ctrl,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [DATA_BITS-1:0] wdata,
    output logic [DATA_BITS-1:0] rd_data,
    output logic                 busy
);

    logic [DATA_BITS-1:0] mem_array [0:(64'd1 << ADDR_BITS) - 64'd1];

    logic [DATA_BITS-1:0] rd_data_reg;
    logic                 clr_busy_reg;
    logic [ADDR_BITS-1:0] clr_addr_reg;

    // Clearing sweep after reset: one word per cycle over the whole memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_BITS'(1);
            if (clr_addr_reg == '1)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Single-port word memory; the sweep owns the port while it runs.
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem_array[clr_addr_reg] <= '0;
        end
        else
        begin
            if (ctrl.wr)
            begin
                mem_array[addr] <= wdata;
            end
            if (ctrl.rd)
            begin
                rd_data_reg <= mem_array[addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

FILE: tb/tb_direct_mapped_write_back_cache_unit.sv
`timescale 1ns / 100ps

module tb_direct_mapped_write_back_cache_unit;
    import dmc_pkg::*;

    localparam logic FUNC_READ    = 1'b0;
    localparam int   NUM_LINES    = 2 ** INDEX_BITS_DEF;
    localparam int   MEM_WORDS    = 2 ** ADDR_BITS_DEF;
    localparam int   RANDOM_ITEMS = 840;
    localparam int   QUIET_ITEMS  = 100;
    // The reset sweep of the backing memory is the longest legal quiet stretch.
    localparam int   IDLE_LIMIT   = 4 * MEM_WORDS;
    localparam int   SETTLE_CYCLES = 4 * (5 + 2 * WORDS_PER_LINE_DEF);

    typedef struct packed {
        logic                 hit;
        logic [DATA_BITS-1:0] read_data;
        logic                 wrote_back;
    } cache_result_t;

    // Mirrors the cache and its backing memory, and keeps the results still owed.
    class cache_scoreboard;
        bit                      line_valid [NUM_LINES];
        bit                      line_dirty [NUM_LINES];
        bit [TAG_BITS_DEF-1:0]   line_tag   [NUM_LINES];
        bit [DATA_BITS-1:0]      line_words [NUM_LINES * WORDS_PER_LINE_DEF];
        bit [DATA_BITS-1:0]      mem_words  [MEM_WORDS];
        cache_result_t           expected_q [$];
        int                      errors;

        function int pending();
            return expected_q.size();
        endfunction

        // Applies one accepted request to the mirror and queues its result.
        function void note_request(logic func, logic [ADDR_BITS_DEF-1:0] address,
                                   logic [DATA_BITS-1:0] write_data);
            bit [OFFSET_BITS_DEF-1:0] offset;
            bit [INDEX_BITS_DEF-1:0]  index;
            bit [TAG_BITS_DEF-1:0]    tag;
            bit [ADDR_BITS_DEF-1:0]   base;
            int                       slot;
            cache_result_t            res;

            offset = address[OFFSET_BITS_DEF-1:0];
            index  = address[OFFSET_BITS_DEF +: INDEX_BITS_DEF];
            tag    = address[ADDR_BITS_DEF-1 -: TAG_BITS_DEF];
            slot   = index * WORDS_PER_LINE_DEF;
            res    = '0;

            if (line_valid[index] && line_tag[index] == tag) begin
                res.hit = 1'b1;
            end
            else begin
                // A dirty victim goes back to the address of its own tag.
                if (line_valid[index] && line_dirty[index]) begin
                    base = {line_tag[index], index, {OFFSET_BITS_DEF{1'b0}}};
                    for (int i = 0; i < WORDS_PER_LINE_DEF; i++)
                        mem_words[base + i] = line_words[slot + i];
                    res.wrote_back = 1'b1;
                end
                base = {tag, index, {OFFSET_BITS_DEF{1'b0}}};
                for (int i = 0; i < WORDS_PER_LINE_DEF; i++)
                    line_words[slot + i] = mem_words[base + i];
                line_tag[index]   = tag;
                line_valid[index] = 1'b1;
                line_dirty[index] = 1'b0;
            end

            if (func == FUNC_WRITE) begin
                line_words[slot + offset] = write_data;
                line_dirty[index]         = 1'b1;
            end
            res.read_data = line_words[slot + offset];
            expected_q.push_back(res);
        endfunction

        // Compares one accepted response against the oldest owed result.
        function void check_response(cache_result_t got);
            cache_result_t exp;

            if (expected_q.size() == 0) begin
                $display("%0t: response with nothing owed: hit=%0b read_data=%h wrote_back=%0b",
                         $time, got.hit, got.read_data, got.wrote_back);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            if (got.hit !== exp.hit) begin
                $display("%0t: hit mismatch: expected %0b, got %0b", $time, exp.hit, got.hit);
                errors++;
            end
            if (got.read_data !== exp.read_data) begin
                $display("%0t: read_data mismatch: expected %h, got %h",
                         $time, exp.read_data, got.read_data);
                errors++;
            end
            if (got.wrote_back !== exp.wrote_back) begin
                $display("%0t: wrote_back mismatch: expected %0b, got %0b",
                         $time, exp.wrote_back, got.wrote_back);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dmc_req_if #(.ADDR_BITS(ADDR_BITS_DEF)) req_if ();
    dmc_rsp_if rsp_if ();

    direct_mapped_write_back_cache_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    cache_scoreboard           sb;
    bit                        gap_enable;
    bit                        stall_enable;
    int                        idle_cycles;
    logic [TAG_BITS_DEF-1:0]   hot_tag   [4];
    logic [INDEX_BITS_DEF-1:0] hot_index [4];

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Sends one request transaction, with an occasional idle burst in front of it.
    task automatic send_request(input logic func, input logic [ADDR_BITS_DEF-1:0] address,
                                input logic [DATA_BITS-1:0] write_data);
        int gap;

        if (gap_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.func       <= func;
        req_if.address    <= address;
        req_if.write_data <= write_data;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
    endtask

    // Holds off new requests until every owed result has come back.
    task automatic drain_responses();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Most addresses land on a few lines and tags so that conflicts are frequent.
    function automatic logic [ADDR_BITS_DEF-1:0] pick_address();
        logic [TAG_BITS_DEF-1:0]   tag;
        logic [INDEX_BITS_DEF-1:0] index;

        if ($urandom_range(0, 9) < 7) begin
            tag   = hot_tag[$urandom_range(0, 3)];
            index = hot_index[$urandom_range(0, 3)];
            return {tag, index, OFFSET_BITS_DEF'($urandom_range(0, WORDS_PER_LINE_DEF - 1))};
        end
        return ADDR_BITS_DEF'($urandom_range(0, MEM_WORDS - 1));
    endfunction

    // Response back-pressure in random bursts.
    initial
    begin
        rsp_if.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (stall_enable && $urandom_range(0, 2) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else begin
                rsp_if.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Transaction monitor and watchdog.
    always @(posedge clk)
    begin
        if (rst_n && req_if.valid && req_if.ready)
            sb.note_request(req_if.func, req_if.address, req_if.write_data);
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_response('{hit: rsp_if.hit, read_data: rsp_if.read_data,
                                wrote_back: rsp_if.wrote_back});
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Main sequence: reset, directed accesses, then random traffic.
    initial
    begin
        sb                = new();
        idle_cycles       = 0;
        gap_enable        = 1'b1;
        stall_enable      = 1'b1;
        rst_n             <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.func       <= FUNC_READ;
        req_if.address    <= '0;
        req_if.write_data <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Cold read miss, then write hit and read hit on the same line.
        send_request(FUNC_READ,  16'h0000, 32'h0000_0000);
        send_request(FUNC_WRITE, 16'h0000, 32'hFFFF_FFFF);
        send_request(FUNC_READ,  16'h0000, 32'hFFFF_FFFF);
        // Write miss on a dirty line: write-back of the old tag, new line left dirty.
        send_request(FUNC_WRITE, 16'h0401, 32'h0000_0000);
        // Bring the old tag back and check that its written-back data survived.
        send_request(FUNC_READ,  16'h0000, 32'h0000_0000);
        // Miss on a clean victim.
        send_request(FUNC_READ,  16'h0401, 32'h1234_5678);
        // Top tag, top index, top offset.
        send_request(FUNC_WRITE, 16'hFFFF, 32'hA5A5_5A5A);
        send_request(FUNC_READ,  16'hFFFC, 32'h0000_0000);
        send_request(FUNC_WRITE, 16'hFFFE, 32'hFFFF_FFFF);
        send_request(FUNC_READ,  16'h03FF, 32'h0000_0000);
        send_request(FUNC_READ,  16'hFFFF, 32'h0000_0000);
        send_request(FUNC_READ,  16'hFFFE, 32'h0000_0000);
        // Writes to two different lines, each left dirty, then read hits on both.
        send_request(FUNC_WRITE, 16'h5402, 32'h5555_5555);
        send_request(FUNC_WRITE, 16'hAB02, 32'hAAAA_AAAA);
        send_request(FUNC_WRITE, 16'h5403, 32'h0F0F_0F0F);
        send_request(FUNC_READ,  16'hAB02, 32'h0000_0000);
        send_request(FUNC_READ,  16'h5402, 32'h0000_0000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                for (int k = 0; k < 4; k++) begin
                    hot_tag[k]   = TAG_BITS_DEF'($urandom());
                    hot_index[k] = INDEX_BITS_DEF'($urandom());
                end
            end
            if (n == RANDOM_ITEMS / 2)
                drain_responses();
            if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
                gap_enable   = 1'b0;
                stall_enable = 1'b0;
            end
            send_request(($urandom_range(0, 1) == 1) ? FUNC_WRITE : FUNC_READ,
                         pick_address(), $urandom());
        end

        drain_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: direct_mapped_write_back_cache_unit.f
sv/dmc_pkg.sv
sv/dmc_if.sv
sv/dmc_line_store.sv
sv/dmc_backing_mem.sv
sv/direct_mapped_write_back_cache_unit.sv
tb/tb_direct_mapped_write_back_cache_unit.sv
